// ===== design/ppg_pkg.sv =====
// shared types, codes, sine table builder and palette functions for the plasma generator
package ppg_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int CFG_WIDTH   = 13;
    localparam int PHASE_BITS  = 9;
    localparam int GRAY_BITS   = 8;

    localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd320;
    localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd240;

    // phase steps
    localparam logic [PHASE_BITS-1:0] PIXEL_STEP_A = 9'd5;
    localparam logic [PHASE_BITS-1:0] PIXEL_STEP_B = 9'd3;
    localparam logic [PHASE_BITS-1:0] ROW_STEP_C   = 9'd1;
    localparam logic [PHASE_BITS-1:0] ROW_STEP_D   = 9'd3;
    localparam logic [PHASE_BITS-1:0] FRAME_STEP_A = 9'd9;
    localparam logic [PHASE_BITS-1:0] FRAME_STEP_C = 9'd8;

    // pi in Q62
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam int QUARTER_ENTRIES = 129;
    localparam int SERIES_TERMS    = 13;

    // four phases that address the sine table for one pixel
    typedef struct packed {
        logic [PHASE_BITS-1:0] pixel_a;
        logic [PHASE_BITS-1:0] pixel_b;
        logic [PHASE_BITS-1:0] row_c;
        logic [PHASE_BITS-1:0] row_d;
    } phase_set_t;

    // quarter wave of 1024*sin, entries 0..128
    typedef logic [10:0] quarter_table_t [QUARTER_ENTRIES];

    // (a * b) >> 62 with a product below 2^126
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // unsigned 64-bit quotient by shift and subtract, evaluated while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // trunc(1024 * sin(k * pi / 256)) by a fixed point taylor series
    function automatic logic [10:0] quarter_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] divisor;
        if (k >= 128)
        begin
            return 11'd1024;
        end
        x = (PI_Q62 >> 8) * 64'(k) + (((PI_Q62 & 64'd255) * 64'(k)) >> 8);
        x2 = mul_q62(x, x);
        term = x;
        sum = x;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            divisor = 64'((2 * n) * (2 * n + 1));
            term = div_u64(mul_q62(term, x2), divisor);
            if ((n & 1) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return sum[62:52];
    endfunction

    function automatic quarter_table_t build_quarter_table();
        quarter_table_t tbl;
        for (int k = 0; k < QUARTER_ENTRIES; k++)
        begin
            tbl[k] = quarter_sine(k);
        end
        return tbl;
    endfunction

    // red ramp palette
    function automatic logic [7:0] red_of(input logic [7:0] g);
        logic [7:0] j4;
        j4 = {g[5:0], 2'b00};
        case (g[7:6])
            2'd0:    return j4;
            2'd1:    return 8'd255;
            2'd2:    return 8'd254 - j4;
            default: return 8'd0;
        endcase
    endfunction

    // green ramp palette
    function automatic logic [7:0] green_of(input logic [7:0] g);
        logic [7:0] j4;
        j4 = {g[5:0], 2'b00};
        case (g[6])
            1'b0:    return 8'd254 - j4;
            default: return j4 + 8'd1;
        endcase
    endfunction

endpackage

// ===== design/ppg_sine_sum.sv =====
// four quarter-wave sine lookups summed into the plasma gray level
module ppg_sine_sum
(
    input  ppg_pkg::phase_set_t           phases,
    output logic [ppg_pkg::GRAY_BITS-1:0] gray_level
);

    localparam ppg_pkg::quarter_table_t QTABLE = ppg_pkg::build_quarter_table();

    // fold a 9-bit phase onto the quarter wave and apply the sign
    function automatic logic signed [11:0] sine_lookup(input logic [ppg_pkg::PHASE_BITS-1:0] p);
        logic [7:0]         k;
        logic signed [11:0] v;
        k = p[7] ? (8'd128 - {1'b0, p[6:0]}) : {1'b0, p[6:0]};
        v = signed'({1'b0, QTABLE[k]});
        return p[8] ? -v : v;
    endfunction

    logic signed [13:0] sine_total;
    logic        [13:0] biased;

    // sum of four lookups, then offset and scale
    always_comb
    begin
        sine_total = 14'(sine_lookup(phases.pixel_a)) + 14'(sine_lookup(phases.pixel_b))
                   + 14'(sine_lookup(phases.row_c)) + 14'(sine_lookup(phases.row_d));
        biased = unsigned'(sine_total + 14'sd4096);
        gray_level = biased[11:4] + 8'd128;
    end

endmodule

// ===== design/plasma_pattern_generator_core.sv =====
// top level of the animated plasma pattern source
// One pixel per accepted input beat, in raster order, one beat per clock: the raster
// counters and phase registers feed the sine lookups and palette combinationally,
// and the pixel lands in an output register. Input ready is high whenever that register
// is empty or is being taken in the same cycle, so a pixel enters every cycle while the
// downstream side keeps up; an accepted beat appears at the output in the next cycle.
module plasma_pattern_generator_core #(
    parameter int DIM_BITS = 12
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ppg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ppg_pkg::CFG_WIDTH-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart_animation,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic                                blue,
    output logic [ppg_pkg::GRAY_BITS-1:0]       gray_level,
    output logic                                end_of_line,
    output logic                                end_of_frame
);

    localparam int PB = ppg_pkg::PHASE_BITS;
    localparam int CW = (DIM_BITS + 1 > ppg_pkg::CFG_WIDTH) ? DIM_BITS + 1 : ppg_pkg::CFG_WIDTH;
    localparam logic [CW-1:0] DIM_MAX = CW'(1) << DIM_BITS;

    logic [ppg_pkg::CFG_WIDTH-1:0] frame_width_reg;
    logic [ppg_pkg::CFG_WIDTH-1:0] frame_height_reg;

    logic [PB-1:0] frame_phase_a_reg, frame_phase_a_next;
    logic [PB-1:0] frame_phase_c_reg, frame_phase_c_next;
    logic [PB-1:0] pixel_phase_a_reg, pixel_phase_a_next;
    logic [PB-1:0] pixel_phase_b_reg, pixel_phase_b_next;
    logic [PB-1:0] row_phase_c_reg, row_phase_c_next;
    logic [PB-1:0] row_phase_d_reg, row_phase_d_next;
    logic [DIM_BITS-1:0] column_count_reg, column_count_next;
    logic [DIM_BITS-1:0] row_count_reg, row_count_next;

    logic out_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [ppg_pkg::GRAY_BITS-1:0] gray_reg;
    logic eol_reg;
    logic eof_reg;

    logic in_fire;
    logic [DIM_BITS-1:0] last_col;
    logic [DIM_BITS-1:0] last_row;
    logic [PB-1:0] cur_frame_a, cur_frame_c, cur_pixel_a, cur_pixel_b, cur_row_c, cur_row_d;
    logic [DIM_BITS-1:0] cur_col, cur_row;
    logic eol_now;
    logic eof_now;
    ppg_pkg::phase_set_t phases;
    logic [ppg_pkg::GRAY_BITS-1:0] gray_now;

    // clamp a size register to 1..2^DIM_BITS and return its last index
    function automatic logic [DIM_BITS-1:0] last_index(input logic [ppg_pkg::CFG_WIDTH-1:0] v);
        logic [CW-1:0] ext;
        logic [CW-1:0] clamped;
        ext = CW'(v);
        if (ext == '0)
        begin
            clamped = CW'(1);
        end
        else if (ext > DIM_MAX)
        begin
            clamped = DIM_MAX;
        end
        else
        begin
            clamped = ext;
        end
        return DIM_BITS'(clamped - CW'(1));
    endfunction

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign last_col = last_index(frame_width_reg);
    assign last_row = last_index(frame_height_reg);

    // state as seen by this beat, after an optional restart
    always_comb
    begin
        if (restart_animation)
        begin
            cur_frame_a = '0;
            cur_frame_c = '0;
            cur_pixel_a = ppg_pkg::PIXEL_STEP_A;
            cur_pixel_b = ppg_pkg::PIXEL_STEP_B;
            cur_row_c   = '0;
            cur_row_d   = '0;
            cur_col     = '0;
            cur_row     = '0;
        end
        else
        begin
            cur_frame_a = frame_phase_a_reg;
            cur_frame_c = frame_phase_c_reg;
            cur_pixel_a = pixel_phase_a_reg;
            cur_pixel_b = pixel_phase_b_reg;
            cur_row_c   = row_phase_c_reg;
            cur_row_d   = row_phase_d_reg;
            cur_col     = column_count_reg;
            cur_row     = row_count_reg;
        end
    end

    assign phases = '{pixel_a: cur_pixel_a, pixel_b: cur_pixel_b,
                      row_c: cur_row_c, row_d: cur_row_d};

    ppg_sine_sum u_sine_sum
    (
        .phases     (phases),
        .gray_level (gray_now)
    );

    // raster position and phase advance
    always_comb
    begin
        eol_now = (cur_col >= last_col);
        eof_now = eol_now && (cur_row >= last_row);
        frame_phase_a_next = cur_frame_a;
        frame_phase_c_next = cur_frame_c;
        row_phase_c_next   = cur_row_c;
        row_phase_d_next   = cur_row_d;
        row_count_next     = cur_row;
        if (eol_now)
        begin
            column_count_next = '0;
            row_phase_c_next  = cur_row_c + ppg_pkg::ROW_STEP_C;
            row_phase_d_next  = cur_row_d + ppg_pkg::ROW_STEP_D;
            if (eof_now)
            begin
                row_count_next     = '0;
                frame_phase_a_next = cur_frame_a + ppg_pkg::FRAME_STEP_A;
                frame_phase_c_next = cur_frame_c + ppg_pkg::FRAME_STEP_C;
                row_phase_c_next   = frame_phase_c_next;
                row_phase_d_next   = '0;
            end
            else
            begin
                row_count_next = cur_row + DIM_BITS'(1);
            end
            pixel_phase_a_next = frame_phase_a_next + ppg_pkg::PIXEL_STEP_A;
            pixel_phase_b_next = ppg_pkg::PIXEL_STEP_B;
        end
        else
        begin
            column_count_next  = cur_col + DIM_BITS'(1);
            pixel_phase_a_next = cur_pixel_a + ppg_pkg::PIXEL_STEP_A;
            pixel_phase_b_next = cur_pixel_b + ppg_pkg::PIXEL_STEP_B;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ppg_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= ppg_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppg_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                ppg_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // animation state, advanced once per input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_phase_a_reg <= '0;
            frame_phase_c_reg <= '0;
            pixel_phase_a_reg <= ppg_pkg::PIXEL_STEP_A;
            pixel_phase_b_reg <= ppg_pkg::PIXEL_STEP_B;
            row_phase_c_reg   <= '0;
            row_phase_d_reg   <= '0;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
        end
        else if (in_fire)
        begin
            frame_phase_a_reg <= frame_phase_a_next;
            frame_phase_c_reg <= frame_phase_c_next;
            pixel_phase_a_reg <= pixel_phase_a_next;
            pixel_phase_b_reg <= pixel_phase_b_next;
            row_phase_c_reg   <= row_phase_c_next;
            row_phase_d_reg   <= row_phase_d_next;
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            red_reg   <= ppg_pkg::red_of(gray_now);
            green_reg <= ppg_pkg::green_of(gray_now);
            gray_reg  <= gray_now;
            eol_reg   <= eol_now;
            eof_reg   <= eof_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = 1'b0;
    assign gray_level   = gray_reg;
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

    // a frame end is always also a line end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!end_of_frame || end_of_line))
        else $error("end_of_frame without end_of_line");

    // an accepted beat always leaves a pixel in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted beat lost");

    // a stalled pixel blocks new input
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken over a stalled pixel");

    // restart mid line puts the raster at the second column
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && restart_animation && !eol_now) |=> (column_count_reg == DIM_BITS'(1)))
        else $error("restart did not reset raster position");

endmodule
